// File: hdl/pkn_pkg.sv
// Package for the peak neighbour search unit: sizes, codes, payload structs.
// No dependencies; used by every module in hdl/.
package pkn_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = 6;
    localparam int COORD_W     = 16;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int PIX_W       = SQ_W + 1;
    localparam int SEED_SQ_W   = 34;
    localparam int MIN_PIX_W   = SEED_SQ_W + 1;
    localparam int ADDR_W      = 5;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } command_t;

    typedef enum logic [2:0]
    {
        ST_NEIGHBOUR = 3'd0,
        ST_NEAREST   = 3'd1,
        ST_NONE      = 3'd2,
        ST_INSERTED  = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0]
    {
        REG_RADIUS  = 3'd0,
        REG_RANGE   = 3'd1,
        REG_COLUMNS = 3'd2,
        REG_ROWS    = 3'd3,
        REG_FRAMES  = 3'd4
    } cfg_reg_t;

    typedef struct packed
    {
        command_t             command;
        logic [COORD_W-1:0]   x_pos;
        logic [COORD_W-1:0]   y_pos;
        logic [COORD_W-1:0]   frame_pos;
    } request_t;

    typedef struct packed
    {
        logic [IDX_W-1:0] entry_index;
        status_t          status;
        logic             last;
    } result_t;

    typedef struct packed
    {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] f;
    } centre_t;

    // One slot of the compare pipeline; tail marks the end of a query walk.
    typedef struct packed
    {
        logic             valid;
        logic             entry;
        logic             tail;
        logic [IDX_W-1:0] idx;
    } token_t;

    typedef struct packed
    {
        token_t             tok;
        logic [PIX_W-1:0]   pix;
        logic [COORD_W-1:0] df;
    } dist_t;

endpackage

// File: hdl/pkn_cell.sv
// One table cell: holds a stored centre and passes it on when the chain shifts.
// Depends on pkn_pkg.
module pkn_cell
(
    input  logic             clk,
    input  logic             shift,
    input  pkn_pkg::centre_t d,
    output pkn_pkg::centre_t q
);

    pkn_pkg::centre_t entry_reg;
    pkn_pkg::centre_t entry_next;

    always_comb
    begin
        entry_next = shift ? d : entry_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// File: hdl/pkn_dist.sv
// Three-stage distance pipeline: abs differences, squares, pixel sum.
// Depends on pkn_pkg.
module pkn_dist
(
    input  logic             clk,
    input  logic             rst_n,
    input  pkn_pkg::token_t  tok,
    input  pkn_pkg::centre_t query,
    input  pkn_pkg::centre_t entry,
    output pkn_pkg::dist_t   dres
);

    pkn_pkg::token_t                 s1_tok_reg, s2_tok_reg, s3_tok_reg;
    logic [pkn_pkg::COORD_W-1:0]     dx_reg, dy_reg, df1_reg, df2_reg, df3_reg;
    logic [pkn_pkg::SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [pkn_pkg::PIX_W-1:0]       pix_reg;
    logic [pkn_pkg::COORD_W-1:0]     dx_next, dy_next, df_next;

    always_comb
    begin
        dx_next = (query.x >= entry.x) ? query.x - entry.x : entry.x - query.x;
        dy_next = (query.y >= entry.y) ? query.y - entry.y : entry.y - query.y;
        df_next = (query.f >= entry.f) ? query.f - entry.f : entry.f - query.f;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
            s3_tok_reg <= '0;
        end
        else
        begin
            s1_tok_reg <= tok;
            s2_tok_reg <= s1_tok_reg;
            s3_tok_reg <= s2_tok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        df1_reg <= df_next;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        df2_reg <= df1_reg;
        pix_reg <= pkn_pkg::PIX_W'(sqx_reg) + pkn_pkg::PIX_W'(sqy_reg);
        df3_reg <= df2_reg;
    end

    always_comb
    begin
        dres.tok = s3_tok_reg;
        dres.pix = pix_reg;
        dres.df  = df3_reg;
    end

endmodule

// File: hdl/peak_neighbour_search_unit.sv
// Top level of the peak neighbour search unit: config regs, cell chain, walk control.
// Depends on pkn_pkg, pkn_cell, pkn_dist.
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  request   | start, busy, request             | in, busy out
//  result    | done, result                     | out
//  config    | psel penable pwrite paddr pwdata | in, prdata/pready out
//
// Insert: result in the cycle after the request, busy stays low.
// Query: busy until the final result; the cell ring rotates once, one entry
// per cycle, through a single distance pipeline. Results come out as found,
// each held back until the next hit, the final one in the same cycle that busy falls.
// Reset empties the table (entry count to zero); registers take their defaults.
// Results cannot be stalled; done is a one-cycle strobe.
module peak_neighbour_search_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pkn_pkg::request_t               request,
    output logic                            done,
    output pkn_pkg::result_t                result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pkn_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int DEPTH = pkn_pkg::TABLE_DEPTH;
    localparam int CW    = pkn_pkg::CNT_W;

    // configuration
    logic [15:0] radius_reg, range_reg;
    logic [12:0] cols_reg, rows_reg;
    logic [11:0] frames_reg;
    logic        cfg_wr;
    pkn_pkg::cfg_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = pkn_pkg::cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            range_reg  <= '0;
            cols_reg   <= 13'd4096;
            rows_reg   <= 13'd4096;
            frames_reg <= 12'd4095;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                pkn_pkg::REG_RADIUS:  radius_reg <= pwdata[15:0];
                pkn_pkg::REG_RANGE:   range_reg  <= pwdata[15:0];
                pkn_pkg::REG_COLUMNS: cols_reg   <= pwdata[12:0];
                pkn_pkg::REG_ROWS:    rows_reg   <= pwdata[12:0];
                pkn_pkg::REG_FRAMES:  frames_reg <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            pkn_pkg::REG_RADIUS:  prdata = {16'd0, radius_reg};
            pkn_pkg::REG_RANGE:   prdata = {16'd0, range_reg};
            pkn_pkg::REG_COLUMNS: prdata = {19'd0, cols_reg};
            pkn_pkg::REG_ROWS:    prdata = {19'd0, rows_reg};
            pkn_pkg::REG_FRAMES:  prdata = {20'd0, frames_reg};
            default:              prdata = '0;
        endcase
    end

    // request decode
    logic accept, ins_go, qry_go, table_full;
    logic [CW-1:0] count_reg, count_next;

    assign accept     = start && !busy;
    assign table_full = (count_reg == CW'(DEPTH));
    assign ins_go     = accept && (request.command == pkn_pkg::CMD_INSERT);
    assign qry_go     = accept && (request.command == pkn_pkg::CMD_QUERY);

    // walk control
    logic          busy_reg, busy_next, run_reg, run_next, seed_reg;
    logic [CW-1:0] step_reg, step_next;
    logic          is_tail, rotate;
    logic [CW:0]   pos_sum;
    pkn_pkg::token_t tok;

    assign is_tail = (step_reg == CW'(DEPTH));
    assign rotate  = run_reg && !is_tail;
    assign pos_sum = {1'b0, step_reg} + {1'b0, count_reg};

    always_comb
    begin
        tok.valid = run_reg;
        tok.tail  = is_tail;
        // entry i sits DEPTH - count + i steps into the rotation
        tok.entry = !is_tail && (pos_sum >= (CW + 1)'(DEPTH));
        tok.idx   = pkn_pkg::IDX_W'(pos_sum - (CW + 1)'(DEPTH));
    end

    // cell chain, new centres enter at cell 0
    pkn_pkg::centre_t cell_q [DEPTH];
    pkn_pkg::centre_t feed, req_centre;
    logic             shift;

    assign req_centre = '{x: request.x_pos, y: request.y_pos, f: request.frame_pos};
    assign shift      = (ins_go && !table_full) || rotate;
    assign feed       = ins_go ? req_centre : cell_q[DEPTH-1];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        pkn_cell u_cell
        (
            .clk   (clk),
            .shift (shift),
            .d     ((i == 0) ? feed : cell_q[(i == 0) ? 0 : i - 1]),
            .q     (cell_q[i])
        );
    end

    pkn_pkg::centre_t query_reg;
    pkn_pkg::dist_t   dres;

    pkn_dist u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok),
        .query (query_reg),
        .entry (cell_q[DEPTH-1]),
        .dres  (dres)
    );

    // seeds and running minima
    logic [31:0]                      rad_sq_reg;
    logic [pkn_pkg::SEED_SQ_W-1:0]    sq_cols_reg, sq_rows_reg;
    logic [pkn_pkg::MIN_PIX_W-1:0]    min_pix_reg, min_pix_next;
    logic [15:0]                      min_frm_reg, min_frm_next;
    logic [pkn_pkg::IDX_W-1:0]        near_idx_reg, near_idx_next;
    logic                             have_near_reg, have_near_next;
    logic [pkn_pkg::IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                             pend_reg, pend_next;
    logic                             done_reg, done_next;
    pkn_pkg::result_t                 result_reg, result_next;
    logic                             better, hit;

    always_comb
    begin
        better = (pkn_pkg::MIN_PIX_W'(dres.pix) < min_pix_reg) && (dres.df < min_frm_reg);
        hit    = (dres.pix < pkn_pkg::PIX_W'(rad_sq_reg)) && (dres.df < range_reg);
    end

    always_comb
    begin
        count_next     = count_reg;
        busy_next      = busy_reg;
        run_next       = run_reg;
        step_next      = step_reg;
        min_pix_next   = min_pix_reg;
        min_frm_next   = min_frm_reg;
        near_idx_next  = near_idx_reg;
        have_near_next = have_near_reg;
        pend_idx_next  = pend_idx_reg;
        pend_next      = pend_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        if (ins_go)
        begin
            done_next = 1'b1;
            result_next.last = 1'b1;
            if (table_full)
            begin
                result_next.entry_index = '0;
                result_next.status      = pkn_pkg::ST_FULL;
            end
            else
            begin
                result_next.entry_index = pkn_pkg::IDX_W'(count_reg);
                result_next.status      = pkn_pkg::ST_INSERTED;
                count_next              = count_reg + 1'b1;
            end
        end

        if (qry_go)
        begin
            busy_next = 1'b1;
            run_next  = 1'b1;
            step_next = '0;
            pend_next = 1'b0;
        end
        else if (run_reg)
        begin
            if (is_tail)
                run_next = 1'b0;
            else
                step_next = step_reg + 1'b1;
        end

        if (seed_reg)
        begin
            min_pix_next   = pkn_pkg::MIN_PIX_W'(sq_cols_reg)
                           + pkn_pkg::MIN_PIX_W'(sq_rows_reg);
            min_frm_next   = {frames_reg, 4'd0};
            have_near_next = 1'b0;
        end

        if (dres.tok.valid && dres.tok.entry)
        begin
            if (better)
            begin
                min_pix_next   = pkn_pkg::MIN_PIX_W'(dres.pix);
                min_frm_next   = dres.df;
                near_idx_next  = dres.tok.idx;
                have_near_next = 1'b1;
            end
            if (hit)
            begin
                // hold each hit back one so the final one can carry last
                if (pend_reg)
                begin
                    done_next   = 1'b1;
                    result_next = '{entry_index: pend_idx_reg,
                                    status: pkn_pkg::ST_NEIGHBOUR, last: 1'b0};
                end
                pend_next     = 1'b1;
                pend_idx_next = dres.tok.idx;
            end
        end
        else if (dres.tok.valid && dres.tok.tail)
        begin
            done_next = 1'b1;
            busy_next = 1'b0;
            pend_next = 1'b0;
            if (pend_reg)
                result_next = '{entry_index: pend_idx_reg,
                                status: pkn_pkg::ST_NEIGHBOUR, last: 1'b1};
            else if (have_near_reg)
                result_next = '{entry_index: near_idx_reg,
                                status: pkn_pkg::ST_NEAREST, last: 1'b1};
            else
                result_next = '{entry_index: '0,
                                status: pkn_pkg::ST_NONE, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            run_reg       <= 1'b0;
            seed_reg      <= 1'b0;
            step_reg      <= '0;
            have_near_reg <= 1'b0;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            run_reg       <= run_next;
            seed_reg      <= qry_go;
            step_reg      <= step_next;
            have_near_reg <= have_near_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_pix_reg  <= min_pix_next;
        min_frm_reg  <= min_frm_next;
        near_idx_reg <= near_idx_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
        if (qry_go)
        begin
            query_reg   <= req_centre;
            rad_sq_reg  <= radius_reg * radius_reg;
            sq_cols_reg <= {cols_reg, 4'd0} * {cols_reg, 4'd0};
            sq_rows_reg <= {rows_reg, 4'd0} * {rows_reg, 4'd0};
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
